### hw/rtl/wcm_pkg.sv
// shared constants, types and helpers for the perspective warp coordinate map
`default_nettype none

package wcm_pkg;

  localparam int REG_W     = 48;
  localparam int COORD_W   = 16;
  localparam int PROD_W    = REG_W + COORD_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int MAG_W     = SUM_W - 1;
  localparam int OUT_W     = 20;
  localparam int REG_CNT   = 8;
  localparam int REG_IDX_W = $clog2(REG_CNT);

  // register indexes on the config port
  localparam logic [REG_IDX_W-1:0] REG_MAP_00 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAP_01 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAP_02 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAP_10 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MAP_11 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MAP_12 = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MAP_20 = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_MAP_21 = 3'd7;

  // 1.0 in q15.32
  localparam logic signed [REG_W-1:0] ONE_Q32 = 48'sh0001_0000_0000;

  localparam int DEF_FIRST_WIDTH   = 4096;
  localparam int DEF_FIRST_HEIGHT  = 4096;
  localparam int DEF_SECOND_WIDTH  = 4096;
  localparam int DEF_SECOND_HEIGHT = 4096;
  localparam int DEF_FRAC_BITS     = 8;

  // control bits riding along with a word through the front stages
  typedef struct packed {
    logic valid;
    logic in2;
  } wcm_ctl_t;

  // control bits leaving the divider
  typedef struct packed {
    logic valid;
    logic in2;
    logic ok_x;
    logic ok_y;
  } wcm_res_t;

  // quotient bits needed to hold any in-range coordinate
  function automatic int quo_bits(input int max_dim, input int frac);
    return $clog2(max_dim + 1) + frac;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/wcm_affine.sv
// two-stage multiply and sum for numerators and perspective divisor
`default_nettype none

module wcm_affine (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  wcm_pkg::wcm_ctl_t                      in_ctl,
  input  logic signed [wcm_pkg::COORD_W-1:0]     x,
  input  logic signed [wcm_pkg::COORD_W-1:0]     y,
  input  logic signed [wcm_pkg::REG_W-1:0]       coef [wcm_pkg::REG_CNT],
  output wcm_pkg::wcm_ctl_t                      out_ctl,
  output logic signed [wcm_pkg::SUM_W-1:0]       nx,
  output logic signed [wcm_pkg::SUM_W-1:0]       ny,
  output logic signed [wcm_pkg::SUM_W-1:0]       den
);
  import wcm_pkg::*;

  wcm_ctl_t                 ctl1;
  logic signed [PROD_W-1:0] px0, px1, py0, py1, pw0, pw1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1    <= '0;
      out_ctl <= '0;
    end else if (en) begin
      ctl1    <= in_ctl;
      out_ctl <= ctl1;
    end
  end

  // stage 1: six products
  always_ff @(posedge clk) begin
    if (en) begin
      px0 <= PROD_W'(coef[REG_MAP_00]) * PROD_W'(x);
      px1 <= PROD_W'(coef[REG_MAP_01]) * PROD_W'(y);
      py0 <= PROD_W'(coef[REG_MAP_10]) * PROD_W'(x);
      py1 <= PROD_W'(coef[REG_MAP_11]) * PROD_W'(y);
      pw0 <= PROD_W'(coef[REG_MAP_20]) * PROD_W'(x);
      pw1 <= PROD_W'(coef[REG_MAP_21]) * PROD_W'(y);
    end
  end

  // stage 2: sums with translation and corner terms
  always_ff @(posedge clk) begin
    if (en) begin
      nx  <= SUM_W'(px0) + SUM_W'(px1) + SUM_W'(coef[REG_MAP_02]);
      ny  <= SUM_W'(py0) + SUM_W'(py1) + SUM_W'(coef[REG_MAP_12]);
      den <= SUM_W'(pw0) + SUM_W'(pw1) + SUM_W'(ONE_Q32);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/wcm_divider.sv
// pipelined restoring divider, one quotient bit per stage for both axes
`default_nettype none

module wcm_divider #(
  parameter int FRAC_BITS = wcm_pkg::DEF_FRAC_BITS,
  parameter int QUO_W     = wcm_pkg::quo_bits(wcm_pkg::DEF_FIRST_WIDTH, wcm_pkg::DEF_FRAC_BITS)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  wcm_pkg::wcm_ctl_t                  in_ctl,
  input  logic signed [wcm_pkg::SUM_W-1:0]   nx,
  input  logic signed [wcm_pkg::SUM_W-1:0]   ny,
  input  logic signed [wcm_pkg::SUM_W-1:0]   den,
  output wcm_pkg::wcm_res_t                  out_res,
  output logic [QUO_W-1:0]                   qx,
  output logic [QUO_W-1:0]                   qy
);
  import wcm_pkg::*;

  localparam int A_W = MAG_W + FRAC_BITS;

  logic           num_x_pos, num_y_pos, den_pos;
  logic           ovf_x, ovf_y;
  logic [A_W-1:0] ax, ay, den_ext;

  // per-stage state; remainder, dividend tail and divisor are dead after the last step
  logic [MAG_W-1:0] rx [QUO_W];
  logic [MAG_W-1:0] ry [QUO_W];
  logic [MAG_W-1:0] dd [QUO_W];
  logic [QUO_W-1:0] lx [QUO_W];
  logic [QUO_W-1:0] ly [QUO_W];
  logic [QUO_W-1:0] qxs [QUO_W+1];
  logic [QUO_W-1:0] qys [QUO_W+1];
  wcm_res_t         st  [QUO_W+1];

  assign num_x_pos = !nx[SUM_W-1] && (nx != '0);
  assign num_y_pos = !ny[SUM_W-1] && (ny != '0);
  assign den_pos   = !den[SUM_W-1] && (den != '0);

  assign ax      = A_W'(nx[MAG_W-1:0]) << FRAC_BITS;
  assign ay      = A_W'(ny[MAG_W-1:0]) << FRAC_BITS;
  assign den_ext = A_W'(den[MAG_W-1:0]);

  // quotient would not fit in QUO_W bits: coordinate is out of range
  assign ovf_x = (ax >> QUO_W) >= den_ext;
  assign ovf_y = (ay >> QUO_W) >= den_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= QUO_W; i++) begin
        st[i] <= '0;
      end
    end else if (en) begin
      st[0] <= '{valid: in_ctl.valid, in2: in_ctl.in2,
                 ok_x: den_pos && num_x_pos && !ovf_x,
                 ok_y: den_pos && num_y_pos && !ovf_y};
      for (int i = 0; i < QUO_W; i++) begin
        st[i+1] <= st[i];
      end
    end
  end

  // setup stage
  always_ff @(posedge clk) begin
    if (en) begin
      rx[0]  <= MAG_W'(ax >> QUO_W);
      ry[0]  <= MAG_W'(ay >> QUO_W);
      lx[0]  <= ax[QUO_W-1:0];
      ly[0]  <= ay[QUO_W-1:0];
      dd[0]  <= den[MAG_W-1:0];
      qxs[0] <= '0;
      qys[0] <= '0;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [MAG_W:0] tx, ty;
    logic           gx, gy;

    assign tx = {rx[k], lx[k][QUO_W-1]};
    assign ty = {ry[k], ly[k][QUO_W-1]};
    assign gx = tx >= {1'b0, dd[k]};
    assign gy = ty >= {1'b0, dd[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        qxs[k+1] <= (qxs[k] << 1) | QUO_W'(gx);
        qys[k+1] <= (qys[k] << 1) | QUO_W'(gy);
      end
    end

    if (k < QUO_W - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          rx[k+1] <= gx ? MAG_W'(tx - {1'b0, dd[k]}) : tx[MAG_W-1:0];
          ry[k+1] <= gy ? MAG_W'(ty - {1'b0, dd[k]}) : ty[MAG_W-1:0];
          lx[k+1] <= lx[k] << 1;
          ly[k+1] <= ly[k] << 1;
          dd[k+1] <= dd[k];
        end
      end
    end
  end

  assign out_res = st[QUO_W];
  assign qx      = qxs[QUO_W];
  assign qy      = qys[QUO_W];

endmodule

`default_nettype wire

### hw/rtl/perspective_warp_coordinate_map.sv
// top level: config registers, pipeline control and output register of the warp map
//
// one word per pixel: canvas_x / canvas_y come in on the in_ channel, the mapped
// first-image coordinate and the inside / blend flags leave on the out_ channel
// both channels: valid from the sender, stall from the receiver; a word moves on
// a clock edge with valid high and stall low
// throughput: one word per cycle, sustained while the receiver does not stall
// path: a word passes the affine product and sum stages, the divider setup stage,
// one divider stage per quotient bit and the output register before out_valid;
// the divider resolves one quotient bit per pipeline stage for both axes in parallel
// the eight map registers are written through cfg_write / cfg_index / cfg_data
// and must only change while the pipeline is empty
// reset (synchronous, rst high) loads the identity map and empties the pipeline
// when the receiver stalls a valid result the whole pipeline freezes and in_stall
// rises in the same cycle; nothing is dropped or repeated
`default_nettype none

module perspective_warp_coordinate_map #(
  parameter int FIRST_WIDTH   = wcm_pkg::DEF_FIRST_WIDTH,
  parameter int FIRST_HEIGHT  = wcm_pkg::DEF_FIRST_HEIGHT,
  parameter int SECOND_WIDTH  = wcm_pkg::DEF_SECOND_WIDTH,
  parameter int SECOND_HEIGHT = wcm_pkg::DEF_SECOND_HEIGHT,
  parameter int FRAC_BITS     = wcm_pkg::DEF_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // config port
  input  logic                                 cfg_write,
  input  logic [wcm_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [wcm_pkg::REG_W-1:0]            cfg_data,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [wcm_pkg::COORD_W-1:0]   canvas_x,
  input  logic signed [wcm_pkg::COORD_W-1:0]   canvas_y,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [wcm_pkg::OUT_W-1:0]            first_x,
  output logic [wcm_pkg::OUT_W-1:0]            first_y,
  output logic                                 inside_first,
  output logic                                 inside_second,
  output logic                                 blend_both
);
  import wcm_pkg::*;

  localparam int MAX_DIM = (FIRST_WIDTH > FIRST_HEIGHT) ? FIRST_WIDTH : FIRST_HEIGHT;
  localparam int QUO_W   = quo_bits(MAX_DIM, FRAC_BITS);

  // strict upper bounds of the mapped coordinate, in fixed point
  localparam logic [QUO_W-1:0] LIM_X = QUO_W'(FIRST_WIDTH * (2 ** FRAC_BITS));
  localparam logic [QUO_W-1:0] LIM_Y = QUO_W'(FIRST_HEIGHT * (2 ** FRAC_BITS));

  localparam logic signed [COORD_W-1:0] SEC_W_LIM = COORD_W'(SECOND_WIDTH);
  localparam logic signed [COORD_W-1:0] SEC_H_LIM = COORD_W'(SECOND_HEIGHT);
  localparam logic signed [COORD_W-1:0] ZERO_C    = COORD_W'(0);

  logic signed [REG_W-1:0] coef [REG_CNT];

  logic                    en;
  logic                    in2;
  logic                    in1;
  wcm_ctl_t                in_ctl, aff_ctl;
  wcm_res_t                div_res;
  logic signed [SUM_W-1:0] nx, ny, den;
  logic [QUO_W-1:0]        qx, qy;

  // map registers, identity after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_CNT; i++) begin
        coef[i] <= '0;
      end
      coef[REG_MAP_00] <= ONE_Q32;
      coef[REG_MAP_11] <= ONE_Q32;
    end else if (cfg_write) begin
      coef[cfg_index] <= $signed(cfg_data);
    end
  end

  // whole pipeline advances unless a finished word is held by the receiver
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // second-image test on the raw input, carried along with the word
  assign in2 = (canvas_x > ZERO_C) && (canvas_y > ZERO_C) &&
               (canvas_x < SEC_W_LIM) && (canvas_y < SEC_H_LIM);

  assign in_ctl = '{valid: in_valid, in2: in2};

  wcm_affine u_affine (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_ctl  (in_ctl),
    .x       (canvas_x),
    .y       (canvas_y),
    .coef    (coef),
    .out_ctl (aff_ctl),
    .nx      (nx),
    .ny      (ny),
    .den     (den)
  );

  wcm_divider #(
    .FRAC_BITS (FRAC_BITS),
    .QUO_W     (QUO_W)
  ) u_divider (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_ctl  (aff_ctl),
    .nx      (nx),
    .ny      (ny),
    .den     (den),
    .out_res (div_res),
    .qx      (qx),
    .qy      (qy)
  );

  // exact inside test: floor(q) < limit is the same as the true quotient < limit
  assign in1 = div_res.ok_x && div_res.ok_y && (qx < LIM_X) && (qy < LIM_Y);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= div_res.valid;
    end
  end

  // output word; coordinates forced to zero outside the first image
  always_ff @(posedge clk) begin
    if (en) begin
      first_x       <= in1 ? OUT_W'(qx) : '0;
      first_y       <= in1 ? OUT_W'(qy) : '0;
      inside_first  <= in1;
      inside_second <= div_res.in2;
      blend_both    <= in1 && div_res.in2;
    end
  end

  // checks

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid set right after reset");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !inside_first |-> (first_x == '0) && (first_y == '0))
    else $error("nonzero coordinate on a word outside the first image");

  a_blend_both: assert property (@(posedge clk) disable iff (rst)
    out_valid && blend_both |-> inside_first && inside_second)
    else $error("blend flag without both inside flags");

  a_stall_backs_up: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while the output word is held");

endmodule

`default_nettype wire

### tb/perspective_warp_coordinate_map_test.sv
// testbench for the perspective warp coordinate map: directed table, random maps, self-checking
`default_nettype none

module perspective_warp_coordinate_map_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wcm_pkg::*;

  // block geometry, kept equal to the instance below
  localparam int FIRST_W  = DEF_FIRST_WIDTH;
  localparam int FIRST_H  = DEF_FIRST_HEIGHT;
  localparam int SECOND_W = DEF_SECOND_WIDTH;
  localparam int SECOND_H = DEF_SECOND_HEIGHT;
  localparam int FRAC     = DEF_FRAC_BITS;

  // q15.32 landmarks
  localparam logic [REG_W-1:0] Q_MAX   = 48'h7FFF_FFFF_FFFF;
  localparam logic [REG_W-1:0] Q_MIN   = 48'h8000_0000_0000;
  localparam logic [REG_W-1:0] Q_NEG1  = 48'hFFFF_0000_0000;
  localparam logic [REG_W-1:0] Q_EDGE  = 48'h1000_0000_0000;  // exactly 4096.0
  localparam logic [REG_W-1:0] Q_UNDER = 48'h0FFF_FFFF_FFFF;  // 4096.0 minus one lsb

  localparam int RAND_PHASES  = 8;
  localparam int PHASE_WORDS  = 175;
  localparam int LONG_HOLD    = 400;  // receiver hold-off, long enough to back up the pipe
  localparam int SETTLE       = 40;   // margin after the last result before the final report
  localparam int REPORT_LIMIT = 10;

  // one result word as the block presents it
  typedef struct packed {
    logic [OUT_W-1:0] fx;
    logic [OUT_W-1:0] fy;
    logic             in1;
    logic             in2;
    logic             both;
  } warp_res_t;

  typedef enum logic [1:0] {ROW_MAP, ROW_WORD, ROW_WORD_KNOWN} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic [REG_IDX_W-1:0]     idx;
    logic [REG_W-1:0]         data;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    warp_res_t                known;
  } dir_row_t;

  logic clk;
  logic rst = 1'b1;

  logic                       cfg_write = 1'b0;
  logic [REG_IDX_W-1:0]       cfg_index = '0;
  logic [REG_W-1:0]           cfg_data  = '0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic signed [COORD_W-1:0]  canvas_x  = '0;
  logic signed [COORD_W-1:0]  canvas_y  = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [OUT_W-1:0]           first_x;
  logic [OUT_W-1:0]           first_y;
  logic                       inside_first;
  logic                       inside_second;
  logic                       blend_both;

  perspective_warp_coordinate_map #(
    .FIRST_WIDTH  (FIRST_W),
    .FIRST_HEIGHT (FIRST_H),
    .SECOND_WIDTH (SECOND_W),
    .SECOND_HEIGHT(SECOND_H),
    .FRAC_BITS    (FRAC)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .canvas_x     (canvas_x),
    .canvas_y     (canvas_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .first_x      (first_x),
    .first_y      (first_y),
    .inside_first (inside_first),
    .inside_second(inside_second),
    .blend_both   (blend_both)
  );

  // shadow of the map registers, identity after reset
  logic signed [REG_W-1:0] warp_map [REG_CNT] = '{ONE_Q32, '0, '0, '0, ONE_Q32, '0, '0, '0};

  warp_res_t mapped_due [$];  // mapped words accepted but not yet seen at the output
  dir_row_t  dir_tab [$];

  // drive bookkeeping so no signal gets two nonblocking writes in one step
  bit offering = 1'b0;
  bit writing  = 1'b0;

  // idling control, shared by both sides
  bit calm      = 1'b0;
  int tx_odds   = 4;
  int rx_odds   = 4;
  bit hold_ask  = 1'b0;
  bit hold_done = 1'b0;
  int rx_hold   = 0;

  int words_sent    = 0;
  int words_checked = 0;
  int bad_words     = 0;
  int reg_writes    = 0;
  int map_settings  = 1;
  int hits_first    = 0;
  int hits_second   = 0;
  int hits_both     = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  initial begin
    #2ms;
    $display("perspective_warp_coordinate_map_test NOT OK");
    $finish;
  end

  // exact quotient of one axis; false when the point is not strictly inside
  function automatic logic axis_map(input logic signed [127:0] num,
                                    input logic signed [127:0] den,
                                    input int lim, output logic [127:0] q);
    logic [127:0] un;
    logic [127:0] ud;
    logic [127:0] lim_q;
    q = '0;
    if (num <= 0) return 1'b0;
    un    = num;
    ud    = den;
    lim_q = 128'(lim);
    q     = (un << FRAC) / ud;
    return q < (lim_q << FRAC);
  endfunction

  // expected word for one canvas coordinate under the current map
  function automatic warp_res_t warp_predict(input logic signed [COORD_W-1:0] cx,
                                             input logic signed [COORD_W-1:0] cy);
    logic signed [127:0] den;
    logic signed [127:0] nx;
    logic signed [127:0] ny;
    logic [127:0]        qx;
    logic [127:0]        qy;
    logic                okx;
    logic                oky;
    warp_res_t           r;
    r     = '0;
    r.in2 = (cx > 0) && (cy > 0) && (cx < SECOND_W) && (cy < SECOND_H);
    // projective divisor, corner term fixed at one
    den = 128'(warp_map[REG_MAP_20]) * 128'(cx) + 128'(warp_map[REG_MAP_21]) * 128'(cy) +
          128'(ONE_Q32);
    if (den > 0) begin
      nx  = 128'(warp_map[REG_MAP_00]) * 128'(cx) + 128'(warp_map[REG_MAP_01]) * 128'(cy) +
            128'(warp_map[REG_MAP_02]);
      ny  = 128'(warp_map[REG_MAP_10]) * 128'(cx) + 128'(warp_map[REG_MAP_11]) * 128'(cy) +
            128'(warp_map[REG_MAP_12]);
      okx = axis_map(nx, den, FIRST_W, qx);
      oky = axis_map(ny, den, FIRST_H, qy);
      if (okx && oky) begin
        r.in1 = 1'b1;
        r.fx  = qx[OUT_W-1:0];
        r.fy  = qy[OUT_W-1:0];
      end
    end
    r.both = r.in1 && r.in2;
    return r;
  endfunction

  // directed table builders
  function automatic void add_map(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    dir_row_t r;
    r.kind  = ROW_MAP;
    r.idx   = idx;
    r.data  = data;
    r.x     = '0;
    r.y     = '0;
    r.known = '0;
    dir_tab.insert(dir_tab.size(), r);
  endfunction

  function automatic void add_word(input int cx, input int cy);
    dir_row_t r;
    r.kind  = ROW_WORD;
    r.idx   = '0;
    r.data  = '0;
    r.x     = 16'(cx);
    r.y     = 16'(cy);
    r.known = '0;
    dir_tab.insert(dir_tab.size(), r);
  endfunction

  // flags are {inside_first, inside_second, blend_both}
  function automatic void add_known(input int cx, input int cy, input int fx, input int fy,
                                    input logic [2:0] flags);
    dir_row_t r;
    r.kind  = ROW_WORD_KNOWN;
    r.idx   = '0;
    r.data  = '0;
    r.x     = 16'(cx);
    r.y     = 16'(cy);
    r.known = {20'(fx), 20'(fy), flags};
    dir_tab.insert(dir_tab.size(), r);
  endfunction

  // random canvas coordinate: mostly around the images, some anywhere, some on the borders
  function automatic logic signed [COORD_W-1:0] pick_coord();
    int k;
    k = $urandom_range(0, 9);
    if (k < 8) return 16'($urandom_range(0, 4300) - 100);
    if (k == 8) return 16'($urandom);
    case ($urandom_range(0, 6))
      0:       return 16'sd0;
      1:       return 16'sd1;
      2:       return 16'sd4095;
      3:       return 16'sd4096;
      4:       return -16'sd1;
      5:       return 16'sh7FFF;
      default: return 16'sh8000;
    endcase
  endfunction

  // q15.32 value spread evenly around a base
  function automatic logic [REG_W-1:0] near(input longint base, input int unsigned span);
    return 48'(base + longint'($urandom_range(0, 2 * span)) - longint'(span));
  endfunction

  // translation of a few thousand pixels with a random fraction
  function automatic logic [REG_W-1:0] shift_q();
    return 48'((longint'($urandom_range(0, 4000)) - 2000) * 64'sd4294967296 + longint'($urandom));
  endfunction

  // anything the register can hold, weighted to the limits
  function automatic logic [REG_W-1:0] wild_q();
    case ($urandom_range(0, 5))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      3:       return ONE_Q32;
      4:       return Q_NEG1;
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  task automatic drop_valid();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic end_writes();
    if (writing) begin
      cfg_write <= 1'b0;
      writing = 1'b0;
    end
  endtask

  // hold the sender until every mapped word has come back
  task automatic drain_results();
    drop_valid();
    while (mapped_due.size() != 0) @(posedge clk);
  endtask

  // one register write; the pipe must already be empty
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_write <= 1'b1;
    writing = 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    warp_map[idx] = val;
    reg_writes++;
  endtask

  // offer one coordinate word, with an occasional gap before it
  task automatic send_word(input logic signed [COORD_W-1:0] cx,
                           input logic signed [COORD_W-1:0] cy,
                           input logic use_known, input warp_res_t known);
    warp_res_t want;
    end_writes();
    if (!calm && tx_odds != 0 && $urandom_range(1, tx_odds) == 1) begin
      drop_valid();
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    offering = 1'b1;
    canvas_x <= cx;
    canvas_y <= cy;
    do @(posedge clk); while (in_stall);
    want = use_known ? known : warp_predict(cx, cy);
    mapped_due.insert(mapped_due.size(), want);
    words_sent++;
    if (want.in1) hits_first++;
    if (want.in2) hits_second++;
    if (want.both) hits_both++;
  endtask

  // output side: check each accepted word, then decide the stall for the next cycle
  always @(posedge clk) begin : result_side
    warp_res_t got;
    warp_res_t want;
    if (out_valid && !out_stall) begin
      got = {first_x, first_y, inside_first, inside_second, blend_both};
      if (mapped_due.size() == 0) begin
        bad_words++;
        if (bad_words <= REPORT_LIMIT)
          $display("unexpected word: x %h y %h flags %b%b%b", got.fx, got.fy,
                   got.in1, got.in2, got.both);
      end else begin
        want = mapped_due.pop_front();
        words_checked++;
        if (got !== want) begin
          bad_words++;
          if (bad_words <= REPORT_LIMIT)
            $display("word %0d mismatch: want x %h y %h flags %b%b%b, got x %h y %h flags %b%b%b",
                     words_checked, want.fx, want.fy, want.in1, want.in2, want.both,
                     got.fx, got.fy, got.in1, got.in2, got.both);
        end
      end
    end
    // one long hold-off on request, otherwise short random bursts
    if (hold_ask && !hold_done) begin
      rx_hold   = LONG_HOLD;
      hold_done = 1'b1;
    end else if (rx_hold == 0 && !calm && rx_odds != 0 && $urandom_range(1, rx_odds) == 1) begin
      rx_hold = $urandom_range(1, 9);
    end
    out_stall <= (rx_hold != 0);
    if (rx_hold != 0) rx_hold--;
  end

  initial begin : stimulus
    int ph;
    int n;
    logic [REG_W-1:0] nm [REG_CNT];

    // identity map straight out of reset, borders and extremes
    add_known(0, 0, 0, 0, 3'b000);
    add_known(1, 1, 'h100, 'h100, 3'b111);
    add_known(4095, 4095, 'hFFF00, 'hFFF00, 3'b111);
    add_known(4096, 1, 0, 0, 3'b000);
    add_known(1, 4096, 0, 0, 3'b000);
    add_known(-32768, -32768, 0, 0, 3'b000);
    add_known(32767, 32767, 0, 0, 3'b000);
    add_known(-1, 7, 0, 0, 3'b000);
    add_known(0, 100, 0, 0, 3'b000);
    add_known(100, 0, 0, 0, 3'b000);
    // divisor 1 - x: zero at x = 1, negative beyond
    add_map(REG_MAP_20, Q_NEG1);
    add_known(1, 1, 0, 0, 3'b010);
    add_known(2, 9, 0, 0, 3'b010);
    add_word(-5, 20);
    add_word(-100, -7);
    // constant x just under the right edge, then exactly on it
    add_map(REG_MAP_20, '0);
    add_map(REG_MAP_00, '0);
    add_map(REG_MAP_02, Q_UNDER);
    add_known(7, 9, 'hFFFFF, 'h900, 3'b111);
    add_map(REG_MAP_02, Q_EDGE);
    add_known(7, 9, 0, 0, 3'b010);
    // smallest positive x still counts as inside, with a zero coordinate
    add_map(REG_MAP_02, 48'h1);
    add_known(7, 9, 0, 'h900, 3'b111);
    // every register at a limit
    add_map(REG_MAP_00, Q_MAX);
    add_map(REG_MAP_01, Q_MIN);
    add_map(REG_MAP_02, Q_MAX);
    add_map(REG_MAP_10, Q_MIN);
    add_map(REG_MAP_11, Q_MAX);
    add_map(REG_MAP_12, Q_MIN);
    add_map(REG_MAP_20, Q_MAX);
    add_map(REG_MAP_21, Q_MIN);
    add_word(32767, -32768);
    add_word(-32768, 32767);
    add_word(1, 1);
    add_word(-1, -1);
    // mild perspective with a 2x horizontal stretch
    add_map(REG_MAP_00, 48'h0002_0000_0000);
    add_map(REG_MAP_01, '0);
    add_map(REG_MAP_02, '0);
    add_map(REG_MAP_10, '0);
    add_map(REG_MAP_11, ONE_Q32);
    add_map(REG_MAP_12, 48'h0000_8000_0000);
    add_map(REG_MAP_20, 48'h0000_0010_0000);
    add_map(REG_MAP_21, 48'h0000_0008_0000);
    add_word(1000, 2000);
    add_word(4095, 1);
    add_word(3000, 3000);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part
    foreach (dir_tab[i]) begin
      case (dir_tab[i].kind)
        ROW_MAP: begin
          if (!writing) begin
            drain_results();
            map_settings++;
          end
          write_reg(dir_tab[i].idx, dir_tab[i].data);
        end
        ROW_WORD:       send_word(dir_tab[i].x, dir_tab[i].y, 1'b0, '0);
        ROW_WORD_KNOWN: send_word(dir_tab[i].x, dir_tab[i].y, 1'b1, dir_tab[i].known);
        default: ;
      endcase
    end

    // random part: a fresh map per phase, near-realistic warps with some wild ones
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 3 || ph == 6) begin
        foreach (nm[i]) nm[i] = wild_q();
      end else begin
        nm[REG_MAP_00] = near(longint'(ONE_Q32), 32'd1 << 30);
        nm[REG_MAP_01] = near(0, 32'd1 << 28);
        nm[REG_MAP_02] = shift_q();
        nm[REG_MAP_10] = near(0, 32'd1 << 28);
        nm[REG_MAP_11] = near(longint'(ONE_Q32), 32'd1 << 30);
        nm[REG_MAP_12] = shift_q();
        nm[REG_MAP_20] = near(0, 32'd1 << 20);
        nm[REG_MAP_21] = near(0, 32'd1 << 20);
      end
      drain_results();
      map_settings++;
      foreach (nm[i]) write_reg(i[REG_IDX_W-1:0], nm[i]);

      // idling mix for this phase; the last one runs flat out
      calm    = (ph == RAND_PHASES - 1);
      tx_odds = (ph % 3 == 0) ? 3 : (ph % 3 == 1) ? 6 : 12;
      rx_odds = (ph % 2 == 0) ? 8 : 3;
      if (ph == 1) hold_ask = 1'b1;

      for (n = 0; n < PHASE_WORDS; n++) begin
        // sender stops mid-phase until the pipe has emptied
        if (ph == 2 && n == PHASE_WORDS / 2) drain_results();
        send_word(pick_coord(), pick_coord(), 1'b0, '0);
      end
    end

    end_writes();
    drop_valid();
    while (mapped_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("%0d words mapped under %0d map settings (%0d register writes)",
             words_sent, map_settings, reg_writes);
    $display("%0d inside the first image, %0d inside the second, %0d blended",
             hits_first, hits_second, hits_both);
    if (bad_words == 0 && mapped_due.size() == 0 && words_checked == words_sent) begin
      $display("perspective_warp_coordinate_map_test OK");
    end else begin
      $display("%0d bad words, %0d still pending", bad_words, mapped_due.size());
      $display("perspective_warp_coordinate_map_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
